// ===== src/ceau_pkg.sv =====
// Shared types, codes and helper functions of the effective-address unit.
package ceau_pkg;

    // Register file geometry: D0-D7 at entries 0-7, A0-A7 at entries 8-15.
    localparam int NUM_REGS  = 16;
    localparam int REG_W     = 32;
    localparam int REG_IDX_W = 4;

    // Index extension word: bit 11 selects a long index instead of a word.
    localparam int IDX_LONG_BIT = 11;

    // Postincrement and predecrement steps.
    localparam logic [2:0] STEP_LONG  = 3'd4;
    localparam logic [2:0] STEP_SHORT = 3'd2;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_SET_REG = 2'd0,
        OP_RESOLVE = 2'd1,
        OP_FLUSH   = 2'd2
    } t_op;

    // Addressing modes.
    typedef enum logic [3:0] {
        MODE_DN_DIRECT = 4'd0,
        MODE_AN_DIRECT = 4'd1,
        MODE_AN_IND    = 4'd2,
        MODE_POSTINC   = 4'd3,
        MODE_PREDEC    = 4'd4,
        MODE_AN_DISP   = 4'd5,
        MODE_AN_INDEX  = 4'd6,
        MODE_ABS_SHORT = 4'd7,
        MODE_ABS_LONG  = 4'd8,
        MODE_PC_DISP   = 4'd9,
        MODE_PC_INDEX  = 4'd10,
        MODE_IMMEDIATE = 4'd11
    } t_mode;

    // Operand sizes after normalisation.
    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_WORD = 2'd1,
        SIZE_LONG = 2'd2
    } t_size;

    // Kinds of memory access reported with a result item.
    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_WRITE = 2'd2
    } t_access;

    // One register file write.
    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] addr;
        logic [REG_W-1:0]     data;
    } t_rf_wr;

    // Keep only the bits of the operand size.
    function automatic logic [REG_W-1:0] clip_to(t_size sz, logic [REG_W-1:0] v);
        logic [REG_W-1:0] r;
        case (sz)
            SIZE_BYTE: r = {24'd0, v[7:0]};
            SIZE_WORD: r = {16'd0, v[15:0]};
            default:   r = v;
        endcase
        return r;
    endfunction

    // Sign-extend from the operand size to the full register width.
    function automatic logic [REG_W-1:0] sext_to(t_size sz, logic [REG_W-1:0] v);
        logic [REG_W-1:0] r;
        case (sz)
            SIZE_BYTE: r = {{24{v[7]}}, v[7:0]};
            SIZE_WORD: r = {{16{v[15]}}, v[15:0]};
            default:   r = v;
        endcase
        return r;
    endfunction

endpackage

// ===== src/ceau_in_if.sv =====
// Input channel of the effective-address unit: handshake and item fields.
interface ceau_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  reg_index;
    logic [3:0]  mode;
    logic [2:0]  ea_reg;
    logic [1:0]  size;
    logic [15:0] ext_word;
    logic [31:0] ext_long;
    logic [31:0] pc_value;
    logic        is_write;
    logic        update;
    logic [31:0] data;

    modport source (
        output valid, op, reg_index, mode, ea_reg, size, ext_word, ext_long,
               pc_value, is_write, update, data,
        input  ready
    );

    modport sink (
        input  valid, op, reg_index, mode, ea_reg, size, ext_word, ext_long,
               pc_value, is_write, update, data,
        output ready
    );
endinterface

// ===== src/ceau_out_if.sv =====
// Output channel of the effective-address unit: handshake and result fields.
interface ceau_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] eff_address;
    logic [1:0]  access_kind;
    logic [31:0] operand_value;
    logic [31:0] store_data;

    modport source (
        output valid, eff_address, access_kind, operand_value, store_data,
        input  ready
    );

    modport sink (
        input  valid, eff_address, access_kind, operand_value, store_data,
        output ready
    );
endinterface

// ===== src/cpu_effective_address_unit_core.sv =====
// Throughput: one item per cycle unless a held result stalls it; each item
// reads the register file into a read-data register in stage one, then one
// pass of address adders and selection fills the result register. Register
// writes made by one item are forwarded to the next.
// Reset clears all control state and the sixteen register valid bits, so
// every register reads as zero until written.
module cpu_effective_address_unit_core
    import ceau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ceau_in_if.sink    i_in,
    ceau_out_if.source o_out
);

    // Register file storage and its valid bits.
    logic [REG_W-1:0]    r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_rf_vld;

    // Stage one: item fields and register read data.
    logic                 r_s1_vld;
    t_op                  r_s1_op;
    logic [REG_IDX_W-1:0] r_s1_reg_index;
    t_mode                r_s1_mode;
    logic [2:0]           r_s1_ea_reg;
    t_size                r_s1_size;
    logic [15:0]          r_s1_ext_word;
    logic [REG_W-1:0]     r_s1_ext_long;
    logic [REG_W-1:0]     r_s1_pc_value;
    logic                 r_s1_is_write;
    logic                 r_s1_update;
    logic [REG_W-1:0]     r_s1_data;
    logic [REG_W-1:0]     r_rd1;
    logic [REG_W-1:0]     r_rd2;

    // Result register.
    logic             r_out_vld;
    logic [REG_W-1:0] r_out_addr;
    t_access          r_out_kind;
    logic [REG_W-1:0] r_out_opv;
    logic [REG_W-1:0] r_out_st;

    logic                 in_acc;
    logic                 s1_adv;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] ra1;
    logic [REG_IDX_W-1:0] ra2;
    t_size                n_size;

    logic [REG_W-1:0] n_addr;
    t_access          n_kind;
    logic [REG_W-1:0] n_opv;
    logic [REG_W-1:0] n_st;
    t_rf_wr           n_wr;

    // Handshake: stage one moves on whenever the result register is free.
    assign s1_adv     = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_s1_vld || s1_adv);
    assign in_acc     = i_in.valid && i_in.ready;
    assign wr_en      = s1_adv && n_wr.we;

    // Read ports: the data or address register named by ea_reg, and the index register.
    assign ra1    = (t_mode'(i_in.mode) == MODE_DN_DIRECT) ? {1'b0, i_in.ea_reg}
                                                           : {1'b1, i_in.ea_reg};
    assign ra2    = i_in.ext_word[15:12];
    assign n_size = (i_in.size == 2'd3) ? SIZE_LONG : t_size'(i_in.size);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_rf_vld  <= '0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (wr_en) begin
                r_rf_vld[n_wr.addr] <= 1'b1;
            end
        end
    end

    // Register file write port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[n_wr.addr] <= n_wr.data;
        end
    end

    // Register file reads with forwarding of the write made in the same cycle.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (wr_en && (n_wr.addr == ra1)) begin
                r_rd1 <= n_wr.data;
            end else begin
                r_rd1 <= r_rf_vld[ra1] ? r_mem[ra1] : '0;
            end
            if (wr_en && (n_wr.addr == ra2)) begin
                r_rd2 <= n_wr.data;
            end else begin
                r_rd2 <= r_rf_vld[ra2] ? r_mem[ra2] : '0;
            end
        end
    end

    // Stage one item fields.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op        <= t_op'(i_in.op);
            r_s1_reg_index <= i_in.reg_index;
            r_s1_mode      <= t_mode'(i_in.mode);
            r_s1_ea_reg    <= i_in.ea_reg;
            r_s1_size      <= n_size;
            r_s1_ext_word  <= i_in.ext_word;
            r_s1_ext_long  <= i_in.ext_long;
            r_s1_pc_value  <= i_in.pc_value;
            r_s1_is_write  <= i_in.is_write;
            r_s1_update    <= i_in.update;
            r_s1_data      <= i_in.data;
        end
    end

    // Address calculation, operand selection and register update.
    always_comb begin
        logic [REG_W-1:0] step;
        logic [REG_W-1:0] idx;
        logic [REG_W-1:0] disp8;
        logic [REG_W-1:0] disp16;
        logic [REG_W-1:0] mask;
        logic [REG_W-1:0] ea;
        logic             mem_acc;

        step    = (r_s1_size == SIZE_LONG) ? REG_W'(STEP_LONG) : REG_W'(STEP_SHORT);
        idx     = r_s1_ext_word[IDX_LONG_BIT] ? r_rd2 : sext_to(SIZE_WORD, r_rd2);
        disp8   = sext_to(SIZE_BYTE, {16'd0, r_s1_ext_word});
        disp16  = sext_to(SIZE_WORD, {16'd0, r_s1_ext_word});
        mask    = clip_to(r_s1_size, '1);
        ea      = '0;
        mem_acc = 1'b0;
        n_opv   = '0;
        n_wr    = '0;

        case (r_s1_op)
            OP_SET_REG: begin
                n_wr = '{we: 1'b1, addr: r_s1_reg_index, data: r_s1_data};
            end
            OP_FLUSH: begin
                if (r_s1_mode == MODE_POSTINC || r_s1_mode == MODE_PREDEC) begin
                    n_wr = '{we: 1'b1, addr: {1'b1, r_s1_ea_reg},
                             data: sext_to(r_s1_size, r_s1_data)};
                end
            end
            OP_RESOLVE: begin
                case (r_s1_mode)
                    MODE_DN_DIRECT: begin
                        if (r_s1_is_write) begin
                            n_wr = '{we: 1'b1, addr: {1'b0, r_s1_ea_reg},
                                     data: (r_rd1 & ~mask) | (r_s1_data & mask)};
                        end else begin
                            n_opv = clip_to(r_s1_size, r_rd1);
                        end
                    end
                    MODE_AN_DIRECT: begin
                        if (r_s1_is_write) begin
                            n_wr = '{we: 1'b1, addr: {1'b1, r_s1_ea_reg},
                                     data: sext_to(r_s1_size, r_s1_data)};
                        end else begin
                            n_opv = clip_to(r_s1_size, r_rd1);
                        end
                    end
                    MODE_AN_IND: begin
                        mem_acc = 1'b1;
                        ea      = r_rd1;
                    end
                    MODE_POSTINC: begin
                        mem_acc = 1'b1;
                        ea      = r_rd1;
                        n_wr    = '{we: r_s1_update, addr: {1'b1, r_s1_ea_reg},
                                    data: r_rd1 + step};
                    end
                    MODE_PREDEC: begin
                        mem_acc = 1'b1;
                        ea      = r_rd1 - step;
                        n_wr    = '{we: r_s1_update, addr: {1'b1, r_s1_ea_reg},
                                    data: r_rd1 - step};
                    end
                    MODE_AN_DISP: begin
                        mem_acc = 1'b1;
                        ea      = r_rd1 + disp16;
                    end
                    MODE_AN_INDEX: begin
                        mem_acc = 1'b1;
                        ea      = r_rd1 + idx + disp8;
                    end
                    MODE_ABS_SHORT: begin
                        mem_acc = 1'b1;
                        ea      = disp16;
                    end
                    MODE_ABS_LONG: begin
                        mem_acc = 1'b1;
                        ea      = r_s1_ext_long;
                    end
                    MODE_PC_DISP: begin
                        mem_acc = 1'b1;
                        ea      = r_s1_pc_value + disp16;
                    end
                    MODE_PC_INDEX: begin
                        mem_acc = 1'b1;
                        ea      = r_s1_pc_value + idx + disp8;
                    end
                    MODE_IMMEDIATE: begin
                        if (!r_s1_is_write) begin
                            n_opv = (r_s1_size == SIZE_LONG) ? r_s1_ext_long
                                  : clip_to(r_s1_size, {16'd0, r_s1_ext_word});
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        // Memory accesses report the address; a write also carries its data.
        if (mem_acc) begin
            n_addr = ea;
            n_kind = r_s1_is_write ? ACC_WRITE : ACC_READ;
            n_st   = r_s1_is_write ? clip_to(r_s1_size, r_s1_data) : '0;
        end else begin
            n_addr = '0;
            n_kind = ACC_NONE;
            n_st   = '0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_addr <= n_addr;
            r_out_kind <= n_kind;
            r_out_opv  <= n_opv;
            r_out_st   <= n_st;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.eff_address   = r_out_addr;
    assign o_out.access_kind   = r_out_kind;
    assign o_out.operand_value = r_out_opv;
    assign o_out.store_data    = r_out_st;

endmodule

// ===== src/ceau_checker.sv =====
// Port-level checks of the effective-address unit and their binding.
module ceau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_eff_address,
    input logic [1:0]  i_out_access_kind,
    input logic [31:0] i_out_operand_value,
    input logic [31:0] i_out_store_data
);

    // A result held back by the sink keeps its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_eff_address)
            && $stable(i_out_access_kind) && $stable(i_out_operand_value)
            && $stable(i_out_store_data))
        else $error("stalled result item changed");

    // A new result appears only after its item was taken and passed through stage one.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result item without a matching input item");

    // A sink that takes results never holds back the input side.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while the output drains");

    // The input side only stalls behind a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a pending result item");

endmodule

bind cpu_effective_address_unit_core ceau_checker u_ceau_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_eff_address   (o_out.eff_address),
    .i_out_access_kind   (o_out.access_kind),
    .i_out_operand_value (o_out.operand_value),
    .i_out_store_data    (o_out.store_data)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the effective-address unit with an in-order operand predictor.
module tb_top;
    import ceau_pkg::*;

    // Codes outside the package enums that the block must still tolerate.
    localparam logic [1:0] OP_RESERVED         = 2'd3;
    localparam logic [3:0] MODE_RESERVED_FIRST = 4'd12;
    localparam logic [3:0] MODE_RESERVED_LAST  = 4'd15;
    localparam logic [1:0] SIZE_CODE_ALIAS     = 2'd3;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_LEN      = 150;
    localparam int SETTLE_CYCLES = 8;

    // One operand request as it crosses the input channel.
    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  reg_index;
        logic [3:0]  mode;
        logic [2:0]  ea_reg;
        logic [1:0]  size;
        logic [15:0] ext_word;
        logic [31:0] ext_long;
        logic [31:0] pc_value;
        logic        is_write;
        logic        update;
        logic [31:0] data;
    } t_ea_item;

    // One operand answer as it crosses the output channel.
    typedef struct packed {
        logic [31:0] eff_address;
        logic [1:0]  access_kind;
        logic [31:0] operand_value;
        logic [31:0] store_data;
    } t_ea_result;

    logic clk;
    logic rst_n;

    ceau_in_if  in_if ();
    ceau_out_if out_if ();

    cpu_effective_address_unit_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow copy of D0-D7 and A0-A7, updated in the order items are accepted.
    logic [31:0] reg_model [NUM_REGS];
    t_ea_result  pending_results [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_seq = 0;
    int          quiet_cycles = 0;

    // Free-running 100 MHz clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mask of the bits that belong to an operand of the given size.
    function automatic logic [31:0] size_mask(input t_size sz);
        if (sz == SIZE_BYTE) return 32'h0000_00FF;
        if (sz == SIZE_WORD) return 32'h0000_FFFF;
        return 32'hFFFF_FFFF;
    endfunction

    // Value taken as a signed operand of the given size and widened to 32 bits.
    function automatic logic [31:0] widen_signed(input t_size sz, input logic [31:0] v);
        logic [31:0] m;
        m = size_mask(sz);
        if ((v & ~(m >> 1)) & m) return v | ~m;
        return v & m;
    endfunction

    // Works out the answer to one accepted item and applies its register changes.
    function automatic t_ea_result predict_operand(input t_ea_item item);
        t_ea_result  res;
        t_size       sz;
        logic [31:0] step;
        logic [31:0] an;
        logic [31:0] addr;
        logic [31:0] idx;
        logic [31:0] m;
        logic [3:0]  an_idx;
        logic        mem;
        res    = '0;
        sz     = (item.size == SIZE_CODE_ALIAS) ? SIZE_LONG : t_size'(item.size);
        step   = (sz == SIZE_LONG) ? 32'(STEP_LONG) : 32'(STEP_SHORT);
        an_idx = {1'b1, item.ea_reg};
        an     = reg_model[an_idx];
        addr   = '0;
        idx    = '0;
        mem    = 1'b1;
        case (item.op)
            OP_SET_REG: reg_model[item.reg_index] = item.data;
            OP_FLUSH: begin
                if (item.mode == MODE_POSTINC || item.mode == MODE_PREDEC)
                    reg_model[an_idx] = widen_signed(sz, item.data);
            end
            OP_RESOLVE: begin
                // Index modes use the word or long form of any register.
                if (item.mode == MODE_AN_INDEX || item.mode == MODE_PC_INDEX) begin
                    idx = reg_model[item.ext_word[15:12]];
                    if (!item.ext_word[IDX_LONG_BIT]) idx = widen_signed(SIZE_WORD, idx);
                    idx = idx + widen_signed(SIZE_BYTE, {24'd0, item.ext_word[7:0]});
                end
                case (item.mode)
                    MODE_DN_DIRECT: begin
                        mem = 1'b0;
                        m   = size_mask(sz);
                        if (item.is_write)
                            reg_model[{1'b0, item.ea_reg}] =
                                (reg_model[{1'b0, item.ea_reg}] & ~m) | (item.data & m);
                        else
                            res.operand_value = reg_model[{1'b0, item.ea_reg}] & m;
                    end
                    MODE_AN_DIRECT: begin
                        mem = 1'b0;
                        if (item.is_write) reg_model[an_idx] = widen_signed(sz, item.data);
                        else res.operand_value = an & size_mask(sz);
                    end
                    MODE_AN_IND: addr = an;
                    MODE_POSTINC: begin
                        addr = an;
                        if (item.update) reg_model[an_idx] = an + step;
                    end
                    MODE_PREDEC: begin
                        addr = an - step;
                        if (item.update) reg_model[an_idx] = addr;
                    end
                    MODE_AN_DISP:   addr = an + widen_signed(SIZE_WORD, {16'd0, item.ext_word});
                    MODE_AN_INDEX:  addr = an + idx;
                    MODE_ABS_SHORT: addr = widen_signed(SIZE_WORD, {16'd0, item.ext_word});
                    MODE_ABS_LONG:  addr = item.ext_long;
                    MODE_PC_DISP:
                        addr = item.pc_value + widen_signed(SIZE_WORD, {16'd0, item.ext_word});
                    MODE_PC_INDEX:  addr = item.pc_value + idx;
                    MODE_IMMEDIATE: begin
                        mem = 1'b0;
                        if (!item.is_write)
                            res.operand_value = (sz == SIZE_LONG) ? item.ext_long
                                : ({16'd0, item.ext_word} & size_mask(sz));
                    end
                    default: mem = 1'b0;
                endcase
                if (mem) begin
                    res.eff_address = addr;
                    if (item.is_write) begin
                        res.access_kind = ACC_WRITE;
                        res.store_data  = item.data & size_mask(sz);
                    end else begin
                        res.access_kind = ACC_READ;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offers one item, with a random gap first, and records its answer once accepted.
    task automatic send_item(input t_ea_item item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= item.op;
        in_if.reg_index <= item.reg_index;
        in_if.mode      <= item.mode;
        in_if.ea_reg    <= item.ea_reg;
        in_if.size      <= item.size;
        in_if.ext_word  <= item.ext_word;
        in_if.ext_long  <= item.ext_long;
        in_if.pc_value  <= item.pc_value;
        in_if.is_write  <= item.is_write;
        in_if.update    <= item.update;
        in_if.data      <= item.data;
        do @(posedge clk); while (!in_if.ready);
        pending_results.push_back(predict_operand(item));
    endtask

    // Stops offering items until every outstanding answer has been checked.
    task automatic await_all_results();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_set(input logic [3:0] idx, input logic [31:0] value);
        t_ea_item item;
        item           = '0;
        item.op        = OP_SET_REG;
        item.reg_index = idx;
        item.data      = value;
        send_item(item);
    endtask

    task automatic send_flush(input logic [3:0] mode, input logic [2:0] areg,
                              input logic [1:0] size, input logic [31:0] value);
        t_ea_item item;
        item        = '0;
        item.op     = OP_FLUSH;
        item.mode   = mode;
        item.ea_reg = areg;
        item.size   = size;
        item.data   = value;
        send_item(item);
    endtask

    task automatic send_resolve(input logic [3:0] mode, input logic [2:0] ea,
                                input logic [1:0] size, input logic [15:0] ext,
                                input logic [31:0] extl, input logic [31:0] pc,
                                input logic wr, input logic upd, input logic [31:0] value);
        t_ea_item item;
        item          = '0;
        item.op       = OP_RESOLVE;
        item.mode     = mode;
        item.ea_reg   = ea;
        item.size     = size;
        item.ext_word = ext;
        item.ext_long = extl;
        item.pc_value = pc;
        item.is_write = wr;
        item.update   = upd;
        item.data     = value;
        send_item(item);
    endtask

    // Random 32-bit value biased towards the corners of the range.
    function automatic logic [31:0] corner_biased_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 32'h0000_0000;
        if (roll < 20) return 32'hFFFF_FFFF;
        if (roll < 25) return 32'h8000_0000;
        if (roll < 30) return 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    // Random item: mostly operand resolves over registers that are loaded along the way.
    function automatic t_ea_item random_operand_item();
        t_ea_item item;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)      item.op = OP_SET_REG;
        else if (roll < 85) item.op = OP_RESOLVE;
        else if (roll < 95) item.op = OP_FLUSH;
        else                item.op = OP_RESERVED;
        item.reg_index = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 6) item.mode = 4'($urandom_range(12, 15));
        else                           item.mode = 4'($urandom_range(0, 11));
        if (item.op == OP_FLUSH && $urandom_range(0, 99) < 70)
            item.mode = $urandom_range(0, 1) ? MODE_POSTINC : MODE_PREDEC;
        item.ea_reg   = 3'($urandom_range(0, 7));
        item.size     = 2'($urandom_range(0, 3));
        item.ext_word = 16'($urandom);
        item.ext_long = corner_biased_word();
        item.pc_value = corner_biased_word();
        item.is_write = 1'($urandom_range(0, 1));
        item.update   = 1'($urandom_range(0, 1));
        item.data     = corner_biased_word();
        return item;
    endfunction

    // Register-direct reads and writes of data and address registers.
    task automatic test_register_access();
        send_set(4'd3, 32'h80FF_7F80);
        send_resolve(MODE_DN_DIRECT, 3'd3, SIZE_BYTE, '0, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_DN_DIRECT, 3'd3, SIZE_WORD, '0, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_DN_DIRECT, 3'd3, SIZE_BYTE, '0, '0, '0, 1'b1, 1'b0, 32'h1234_56AB);
        send_resolve(MODE_DN_DIRECT, 3'd3, SIZE_LONG, '0, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_AN_DIRECT, 3'd2, SIZE_WORD, '0, '0, '0, 1'b1, 1'b0, 32'h0000_8001);
        send_resolve(MODE_AN_DIRECT, 3'd2, SIZE_LONG, '0, '0, '0, 1'b0, 1'b0, '0);
        send_set(4'd15, 32'hFFFF_FFFF);
        send_resolve(MODE_AN_DIRECT, 3'd7, SIZE_WORD, '0, '0, '0, 1'b0, 1'b0, '0);
        await_all_results();
    endtask

    // Every memory addressing mode plus immediates, with the awkward edges of each.
    task automatic test_memory_modes();
        send_set(4'd10, 32'h0000_1000);
        send_resolve(MODE_AN_IND, 3'd2, SIZE_LONG, '0, '0, '0, 1'b0, 1'b0, '0);
        // A byte step through A7 is still two, and the address wraps.
        send_resolve(MODE_POSTINC, 3'd7, SIZE_BYTE, '0, '0, '0, 1'b0, 1'b1, '0);
        send_resolve(MODE_POSTINC, 3'd7, SIZE_LONG, '0, '0, '0, 1'b1, 1'b1, 32'hDEAD_BEEF);
        send_resolve(MODE_PREDEC, 3'd2, SIZE_LONG, '0, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_PREDEC, 3'd2, SIZE_WORD, '0, '0, '0, 1'b1, 1'b1, 32'hFFFF_8765);
        send_resolve(MODE_AN_DISP, 3'd2, SIZE_WORD, 16'h8000, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_AN_INDEX, 3'd2, SIZE_BYTE, 16'hF880, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_AN_INDEX, 3'd2, SIZE_WORD, 16'h307F, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_ABS_SHORT, 3'd0, SIZE_WORD, 16'h8000, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_ABS_LONG, 3'd0, SIZE_BYTE, '0, 32'hFFFF_FFFF, '0, 1'b1, 1'b0,
                     32'hFFFF_FF5A);
        send_resolve(MODE_PC_DISP, 3'd0, SIZE_LONG, 16'h0004, '0, 32'hFFFF_FFFE, 1'b0,
                     1'b0, '0);
        send_resolve(MODE_PC_INDEX, 3'd0, SIZE_LONG, 16'hA0FF, '0, 32'h0000_0100, 1'b0,
                     1'b0, '0);
        send_resolve(MODE_IMMEDIATE, 3'd0, SIZE_BYTE, 16'hABCD, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_IMMEDIATE, 3'd0, SIZE_WORD, 16'hABCD, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_IMMEDIATE, 3'd0, SIZE_LONG, 16'hABCD, 32'h8765_4321, '0, 1'b0,
                     1'b0, '0);
        // A write to an immediate is dropped.
        send_resolve(MODE_IMMEDIATE, 3'd0, SIZE_LONG, 16'hABCD, 32'h8765_4321, '0, 1'b1,
                     1'b1, 32'hFFFF_FFFF);
        await_all_results();
    endtask

    // Flushes, the long alias of size code three, unused modes and the unused op code.
    task automatic test_special_cases();
        t_ea_item item;
        send_flush(MODE_POSTINC, 3'd4, SIZE_BYTE, 32'h0000_0080);
        send_flush(MODE_PREDEC, 3'd5, SIZE_WORD, 32'hFFFF_1234);
        send_flush(MODE_AN_IND, 3'd6, SIZE_LONG, 32'hFFFF_FFFF);
        send_resolve(MODE_AN_DIRECT, 3'd4, SIZE_LONG, '0, '0, '0, 1'b0, 1'b0, '0);
        send_resolve(MODE_PREDEC, 3'd4, SIZE_CODE_ALIAS, '0, '0, '0, 1'b1, 1'b1,
                     32'hCAFE_F00D);
        send_resolve(MODE_RESERVED_FIRST, 3'd1, SIZE_LONG, 16'hFFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_resolve(MODE_RESERVED_LAST, 3'd7, SIZE_LONG, 16'hFFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        item        = random_operand_item();
        item.op     = OP_RESERVED;
        item.mode   = MODE_POSTINC;
        item.update = 1'b1;
        send_item(item);
        send_resolve(MODE_AN_DIRECT, 3'd6, SIZE_LONG, '0, '0, '0, 1'b0, 1'b0, '0);
        await_all_results();
    endtask

    // A burst of random items under the given idle rates on each side.
    task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) send_item(random_operand_item());
        await_all_results();
    endtask

    // The receiver stops for a long stretch while items keep coming, so the input backs up.
    task automatic test_output_stall();
        send_idle_pct = 0;
        hold_seq      = hold_seq + 1;
        repeat (40) send_item(random_operand_item());
        await_all_results();
    endtask

    // Receiver: random ready, or held low for a stretch when a hold is requested.
    initial begin : receiver
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seq != hold_seen) begin
                hold_seen  = hold_seq;
                stall_left = HOLD_LEN;
            end
            if (stall_left > 0) begin
                stall_left   = stall_left - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Each accepted result is compared with the oldest outstanding answer.
    always @(posedge clk) begin : result_check
        t_ea_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result item addr=%h kind=%0d value=%h store=%h",
                         $time, out_if.eff_address, out_if.access_kind,
                         out_if.operand_value, out_if.store_data);
            end else begin
                want = pending_results.pop_front();
                if (out_if.eff_address !== want.eff_address) begin
                    mismatches++;
                    $display("%0t: eff_address expected %h actual %h",
                             $time, want.eff_address, out_if.eff_address);
                end
                if (out_if.access_kind !== want.access_kind) begin
                    mismatches++;
                    $display("%0t: access_kind expected %0d actual %0d",
                             $time, want.access_kind, out_if.access_kind);
                end
                if (out_if.operand_value !== want.operand_value) begin
                    mismatches++;
                    $display("%0t: operand_value expected %h actual %h",
                             $time, want.operand_value, out_if.operand_value);
                end
                if (out_if.store_data !== want.store_data) begin
                    mismatches++;
                    $display("%0t: store_data expected %h actual %h",
                             $time, want.store_data, out_if.store_data);
                end
            end
        end
    end

    // Watchdog: ends the run if no item moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        foreach (reg_model[i]) reg_model[i] = '0;
        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.op        <= '0;
        in_if.reg_index <= '0;
        in_if.mode      <= '0;
        in_if.ea_reg    <= '0;
        in_if.size      <= '0;
        in_if.ext_word  <= '0;
        in_if.ext_long  <= '0;
        in_if.pc_value  <= '0;
        in_if.is_write  <= 1'b0;
        in_if.update    <= 1'b0;
        in_if.data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 59;
        test_register_access();
        test_memory_modes();
        test_special_cases();
        test_random_traffic(300, 19, 59);
        test_random_traffic(300, 59, 19);
        test_output_stall();
        test_random_traffic(250, 0, 0);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
